>>> sv/tcbs_pkg.sv
// ----------------------------------------------------------------------------
// tcbs_pkg: shared definitions for the three-channel balance setpoint block
// Field widths, register indexes and reset values, the back-end state type
// and the setpoint saturation helper.
// ----------------------------------------------------------------------------
package tcbs_pkg;

  // Default width of a channel voltage, signed Q16.16 at 32 bits.
  localparam int VOLT_WIDTH_DEF = 32;

  // Fixed field widths.
  localparam int FRAME_ID_W   = 11;
  localparam int FULL_SCALE_W = 21;
  localparam int DEAD_BAND_W  = 17;
  localparam int FINE_GAIN_W  = 21;
  localparam int SETPOINT_W   = 22;
  localparam int CHAN_W       = 2;
  localparam int NUM_CHAN     = 3;
  localparam int FRAC_W       = 16;

  // Configuration port.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 21;

  // Setpoint magnitude limit, 16.0 in Q16.16.
  localparam logic [FULL_SCALE_W-1:0] OUT_LIMIT = 21'd1048576;

  // Register reset values.
  localparam logic [FRAME_ID_W-1:0]   BASE_ID_RST    = 11'd16;
  localparam logic [FULL_SCALE_W-1:0] FULL_SCALE_RST = 21'd262144;
  localparam logic [DEAD_BAND_W-1:0]  DEAD_BAND_RST  = 17'd655;
  localparam logic [FINE_GAIN_W-1:0]  FINE_GAIN_RST  = 21'd327680;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_BASE_ID    = 2'd0,
    CFG_FULL_SCALE = 2'd1,
    CFG_DEAD_BAND  = 2'd2,
    CFG_FINE_GAIN  = 2'd3
  } cfg_index_t;

  // Register contents that the back end needs.
  typedef struct packed {
    logic [FULL_SCALE_W-1:0] full_scale;
    logic [DEAD_BAND_W-1:0]  dead_band;
    logic [FINE_GAIN_W-1:0]  fine_gain;
  } calc_cfg_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    B_IDLE,
    B_SUM,
    B_MEAN,
    B_DEV,
    B_BEST,
    B_RATIO,
    B_FINE,
    B_FINISH
  } back_state_t;

  // Limit a magnitude to the output range and apply the sign.
  function automatic logic signed [SETPOINT_W-1:0] sat_setpoint(
    input logic [FULL_SCALE_W-1:0] m,
    input logic                    neg
  );
    logic [FULL_SCALE_W-1:0] lim;
    logic [SETPOINT_W-1:0]   v;
    lim = (m > OUT_LIMIT) ? OUT_LIMIT : m;
    v   = {1'b0, lim};
    return neg ? $signed(~v + 1'b1) : $signed(v);
  endfunction

endpackage

>>> sv/tcbs_front.sv
// ----------------------------------------------------------------------------
// tcbs_front: frame classifier
// Accepts input beats, matches the identifier against the three-frame window
// and forwards matching voltages with their channel index to the queue.
// ----------------------------------------------------------------------------
module tcbs_front #(
  parameter int VOLT_WIDTH = tcbs_pkg::VOLT_WIDTH_DEF
) (
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [tcbs_pkg::FRAME_ID_W-1:0]     frame_id,
  input  logic [VOLT_WIDTH-1:0]               voltage,
  input  logic [tcbs_pkg::FRAME_ID_W-1:0]     base_frame_id,
  output logic                                push_valid,
  input  logic                                push_ready,
  output logic [tcbs_pkg::CHAN_W+VOLT_WIDTH-1:0] push_data
);
  import tcbs_pkg::*;

  logic [FRAME_ID_W:0] id_diff;
  logic                id_match;

  // Offset from the base identifier; no wrap past the top of the id space.
  assign id_diff  = {1'b0, frame_id} - {1'b0, base_frame_id};
  assign id_match = !id_diff[FRAME_ID_W] && (id_diff[FRAME_ID_W-1:0] <= FRAME_ID_W'(2));

  // Non-matching beats are taken and dropped.
  assign in_ready   = push_ready;
  assign push_valid = in_valid && id_match;
  assign push_data  = {voltage, id_diff[CHAN_W-1:0]};

endmodule

>>> sv/tcbs_queue.sv
// ----------------------------------------------------------------------------
// tcbs_queue: two-entry queue between classifier and calculator
// Lets the front end keep taking beats while the back end is busy.
// ----------------------------------------------------------------------------
module tcbs_queue #(
  parameter int WIDTH = tcbs_pkg::CHAN_W + tcbs_pkg::VOLT_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  import tcbs_pkg::*;

  logic [WIDTH-1:0] entries [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> sv/tcbs_back.sv
// ----------------------------------------------------------------------------
// tcbs_back: setpoint calculator
// Holds the three channel voltages, divides their sum by three with a
// reciprocal multiply, finds the most deviant channel, runs three serial
// ratio lanes and a shared fine-gain multiplier, then loads the result
// register.
// ----------------------------------------------------------------------------
module tcbs_back #(
  parameter int VOLT_WIDTH = tcbs_pkg::VOLT_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   pop_valid,
  output logic                                   pop_ready,
  input  logic [tcbs_pkg::CHAN_W+VOLT_WIDTH-1:0] pop_data,
  input  tcbs_pkg::calc_cfg_t                    cfg,
  output logic                                   res_valid,
  input  logic                                   res_ready,
  output logic signed [tcbs_pkg::SETPOINT_W-1:0] res_setpoint [tcbs_pkg::NUM_CHAN],
  output logic [tcbs_pkg::CHAN_W-1:0]            res_most_deviant
);
  import tcbs_pkg::*;

  localparam int SUM_W      = VOLT_WIDTH + 2;
  localparam int ABS_W      = VOLT_WIDTH + 1;
  localparam int LO_W       = (ABS_W + 1) / 2;
  localparam int PP_W       = LO_W + ABS_W;
  localparam int ACC_W      = 2 * ABS_W;
  localparam int NUM_W      = ABS_W + 2;
  localparam int MEAN_STEPS = 2;
  localparam int DEV_W      = VOLT_WIDTH + 2;
  localparam int MAG_W      = VOLT_WIDTH + 1;
  localparam int REM_W      = MAG_W + 2;
  localparam int CMP_W      = (MAG_W > DEAD_BAND_W) ? MAG_W : DEAD_BAND_W;
  localparam int PROD_W     = FINE_GAIN_W + DEAD_BAND_W;
  localparam int MAX_STEP   = (MEAN_STEPS > FULL_SCALE_W) ? MEAN_STEPS : FULL_SCALE_W;
  localparam int CNT_W      = $clog2(MAX_STEP + 1);

  // Reciprocal of three rounded up at 2^(ABS_W+1); the quotient taken from
  // the top of the product is exact for every ABS_W-bit dividend.
  localparam logic [NUM_W-1:0] RECIP_NUM = NUM_W'(1) << (ABS_W + 1);
  localparam logic [ABS_W-1:0] RECIP     = ABS_W'((RECIP_NUM + NUM_W'(2)) / NUM_W'(3));

  back_state_t state;
  back_state_t state_next;

  logic signed [VOLT_WIDTH-1:0] volt [NUM_CHAN];

  // Divide-by-three state.
  logic             sum_neg;
  logic [ABS_W-1:0] sum_mag;
  logic [ACC_W-1:0] mean_acc;
  logic [CNT_W-1:0] cnt;

  // Deviations and selection.
  logic signed [DEV_W-1:0] dev [NUM_CHAN];
  logic [MAG_W-1:0]        mag [NUM_CHAN];
  logic [CHAN_W-1:0]       best;
  logic [MAG_W-1:0]        best_mag;
  logic                    best_neg;

  // Ratio lanes and fine-gain results.
  logic [FULL_SCALE_W-1:0] rq [NUM_CHAN];
  logic [REM_W-1:0]        rr [NUM_CHAN];
  logic [FULL_SCALE_W-1:0] fs_sh;
  logic [FULL_SCALE_W-1:0] fine_mag [NUM_CHAN];

  // Combinational helpers.
  logic signed [SUM_W-1:0]      sum_calc;
  logic [SUM_W-1:0]             sum_abs;
  logic [LO_W-1:0]              pp_sel;
  logic [PP_W-1:0]              pp;
  logic [ACC_W-1:0]             pp_add;
  logic [VOLT_WIDTH:0]          mean_mag;
  logic [VOLT_WIDTH:0]          mean_calc;
  logic signed [DEV_W-1:0]      dev_calc [NUM_CHAN];
  logic [DEV_W-1:0]             dev_abs  [NUM_CHAN];
  logic [CHAN_W-1:0]            best_calc;
  logic [REM_W-1:0]             step_sh  [NUM_CHAN];
  logic [REM_W-1:0]             step_d;
  logic [REM_W-1:0]             step_d2;
  logic [CMP_W-1:0]             fine_sel;
  logic [PROD_W-1:0]            fine_prod;
  logic signed [SETPOINT_W-1:0] sp_calc [NUM_CHAN];
  logic                         out_free;
  logic                         mean_last;
  logic                         ratio_last;
  logic                         fine_last;

  assign out_free   = !res_valid || res_ready;
  assign mean_last  = (cnt == CNT_W'(MEAN_STEPS - 1));
  assign ratio_last = (cnt == CNT_W'(FULL_SCALE_W - 1));
  assign fine_last  = (cnt == CNT_W'(NUM_CHAN - 1));

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:   if (pop_valid) state_next = B_SUM;
      B_SUM:    state_next = B_MEAN;
      B_MEAN:   if (mean_last) state_next = B_DEV;
      B_DEV:    state_next = B_BEST;
      B_BEST:   state_next = B_RATIO;
      B_RATIO:  if (ratio_last) state_next = B_FINE;
      B_FINE:   if (fine_last) state_next = B_FINISH;
      B_FINISH: if (out_free) state_next = B_IDLE;
      default:  state_next = B_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    case (state)
      B_IDLE:  pop_ready = 1'b1;
      default: pop_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Signed sum of the stored voltages and its magnitude.
  always_comb begin
    sum_calc = {{2{volt[0][VOLT_WIDTH-1]}}, volt[0]}
             + {{2{volt[1][VOLT_WIDTH-1]}}, volt[1]}
             + {{2{volt[2][VOLT_WIDTH-1]}}, volt[2]};
    sum_abs  = sum_calc[SUM_W-1] ? (~sum_calc + 1'b1) : sum_calc;
  end

  // One partial product of the sum magnitude and the reciprocal: the low
  // half first, then the high half shifted into place.
  always_comb begin
    pp_sel = cnt[0] ? LO_W'(sum_mag[ABS_W-1:LO_W]) : sum_mag[LO_W-1:0];
    pp     = PP_W'(pp_sel) * PP_W'(RECIP);
    pp_add = cnt[0] ? (ACC_W'(pp) << LO_W) : ACC_W'(pp);
  end

  // Mean truncated toward zero, then each channel's deviation.
  always_comb begin
    mean_mag  = {1'b0, mean_acc[ABS_W+1 +: VOLT_WIDTH]};
    mean_calc = sum_neg ? (~mean_mag + 1'b1) : mean_mag;
    for (int i = 0; i < NUM_CHAN; i++) begin
      dev_calc[i] = $signed({mean_calc[VOLT_WIDTH], mean_calc})
                  - $signed({{2{volt[i][VOLT_WIDTH-1]}}, volt[i]});
      dev_abs[i]  = dev_calc[i][DEV_W-1] ? (~dev_calc[i] + 1'b1) : dev_calc[i];
    end
  end

  // Largest magnitude, lowest index on a tie.
  always_comb begin
    best_calc = 2'd0;
    if (mag[1] > mag[0]) begin
      best_calc = 2'd1;
    end
    if (mag[2] > mag[best_calc]) begin
      best_calc = 2'd2;
    end
  end

  // One step of floor(mag * full_scale / best_mag) in each lane.
  always_comb begin
    step_d  = REM_W'(best_mag);
    step_d2 = REM_W'({best_mag, 1'b0});
    for (int i = 0; i < NUM_CHAN; i++) begin
      step_sh[i] = {rr[i][REM_W-2:0], 1'b0}
                 + (fs_sh[FULL_SCALE_W-1] ? REM_W'(mag[i]) : REM_W'(0));
    end
  end

  // Shared fine-gain multiplier; only used on magnitudes inside the dead band.
  always_comb begin
    fine_sel  = CMP_W'(mag[cnt[CHAN_W-1:0]]);
    fine_prod = PROD_W'(cfg.fine_gain) * PROD_W'(fine_sel[DEAD_BAND_W-1:0]);
  end

  // Final setpoint of each channel.
  always_comb begin
    for (int i = 0; i < NUM_CHAN; i++) begin
      if (CMP_W'(mag[i]) <= CMP_W'(cfg.dead_band)) begin
        sp_calc[i] = sat_setpoint(fine_mag[i], !dev[i][DEV_W-1]);
      end else if (best == CHAN_W'(i)) begin
        sp_calc[i] = sat_setpoint(cfg.full_scale,
                                  !dev[i][DEV_W-1] && (dev[i] != '0));
      end else begin
        sp_calc[i] = sat_setpoint(rq[i], dev[i][DEV_W-1] != best_neg);
      end
    end
  end

  // Stored voltages clear at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHAN; i++) begin
        volt[i] <= '0;
      end
    end else if (state == B_IDLE && pop_valid) begin
      volt[pop_data[CHAN_W-1:0]] <= pop_data[CHAN_W+VOLT_WIDTH-1:CHAN_W];
    end
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      case (state)
        B_MEAN:  cnt <= mean_last ? '0 : cnt + 1'b1;
        B_RATIO: cnt <= ratio_last ? '0 : cnt + 1'b1;
        B_FINE:  cnt <= fine_last ? '0 : cnt + 1'b1;
        default: cnt <= '0;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      B_SUM: begin
        sum_neg  <= sum_calc[SUM_W-1];
        sum_mag  <= sum_abs[ABS_W-1:0];
        mean_acc <= '0;
      end
      B_MEAN: begin
        mean_acc <= mean_acc + pp_add;
      end
      B_DEV: begin
        for (int i = 0; i < NUM_CHAN; i++) begin
          dev[i] <= dev_calc[i];
          mag[i] <= dev_abs[i][MAG_W-1:0];
        end
      end
      B_BEST: begin
        best     <= best_calc;
        best_mag <= mag[best_calc];
        best_neg <= dev[best_calc][DEV_W-1];
        fs_sh    <= cfg.full_scale;
        for (int i = 0; i < NUM_CHAN; i++) begin
          rq[i] <= '0;
          rr[i] <= '0;
        end
      end
      B_RATIO: begin
        fs_sh <= {fs_sh[FULL_SCALE_W-2:0], 1'b0};
        for (int i = 0; i < NUM_CHAN; i++) begin
          if (step_sh[i] >= step_d2) begin
            rr[i] <= step_sh[i] - step_d2;
            rq[i] <= {rq[i][FULL_SCALE_W-2:0], 1'b0} + FULL_SCALE_W'(2);
          end else if (step_sh[i] >= step_d) begin
            rr[i] <= step_sh[i] - step_d;
            rq[i] <= {rq[i][FULL_SCALE_W-2:0], 1'b1};
          end else begin
            rr[i] <= step_sh[i];
            rq[i] <= {rq[i][FULL_SCALE_W-2:0], 1'b0};
          end
        end
      end
      B_FINE: begin
        // A scaled product too large for the field saturates.
        fine_mag[cnt[CHAN_W-1:0]] <= (|fine_prod[PROD_W-1:FRAC_W+FULL_SCALE_W]) ?
                                     OUT_LIMIT : fine_prod[FRAC_W+FULL_SCALE_W-1:FRAC_W];
      end
      default: begin
      end
    endcase
  end

  // Result register; the next item is computed while a result waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == B_FINISH && out_free) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_FINISH && out_free) begin
      for (int i = 0; i < NUM_CHAN; i++) begin
        res_setpoint[i] <= sp_calc[i];
      end
      res_most_deviant <= best;
    end
  end

endmodule

>>> sv/three_channel_balance_setpoints_top.sv
// ----------------------------------------------------------------------------
// three_channel_balance_setpoints_top: three-channel balancing setpoints
// Input beats carry a frame identifier and a channel voltage. Frames for the
// three channels of the window update a stored voltage and produce one beat
// of setpoints; all other frames are consumed without a result.
//
// Usage:
//   s_axis carries input beats, m_axis carries result beats and cfg writes
//   the four registers (always ready; write only while the block is idle).
//   A matching beat passes through the queue, the sum, the reciprocal
//   multiply that divides by three, deviations and selection, the serial
//   ratio lanes (one bit of full_scale a cycle), the shared fine-gain
//   multiplier one channel at a time, and the result register load.
//   The back end takes no new item until the previous result is loaded.
//   A two-entry queue lets two more beats be taken while one is computed,
//   and the next item runs while a finished result waits on m_axis_tready.
//   Reset clears the stored voltages to zero, loads the register defaults
//   and empties the queue and result register.
// ----------------------------------------------------------------------------
module three_channel_balance_setpoints_top #(
  parameter int VOLT_WIDTH = tcbs_pkg::VOLT_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Input beats.
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata: frame_id, voltage, zero fill to whole bytes
  input  logic [((tcbs_pkg::FRAME_ID_W+VOLT_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // Result beats.
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // tdata: setpoint_first, setpoint_second, setpoint_third, most_deviant, zero fill
  output logic [71:0]                          m_axis_tdata,
  // Register writes.
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tcbs_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [tcbs_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import tcbs_pkg::*;

  localparam int Q_W = CHAN_W + VOLT_WIDTH;

  logic [FRAME_ID_W-1:0]        base_frame_id;
  calc_cfg_t                    calc_cfg;
  logic                         push_valid;
  logic                         push_ready;
  logic [Q_W-1:0]               push_data;
  logic                         pop_valid;
  logic                         pop_ready;
  logic [Q_W-1:0]               pop_data;
  logic signed [SETPOINT_W-1:0] res_setpoint [NUM_CHAN];
  logic [CHAN_W-1:0]            res_most_deviant;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_frame_id       <= BASE_ID_RST;
      calc_cfg.full_scale <= FULL_SCALE_RST;
      calc_cfg.dead_band  <= DEAD_BAND_RST;
      calc_cfg.fine_gain  <= FINE_GAIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_t'(cfg_index))
        CFG_BASE_ID:    base_frame_id       <= cfg_data[FRAME_ID_W-1:0];
        CFG_FULL_SCALE: calc_cfg.full_scale <= cfg_data[FULL_SCALE_W-1:0];
        CFG_DEAD_BAND:  calc_cfg.dead_band  <= cfg_data[DEAD_BAND_W-1:0];
        CFG_FINE_GAIN:  calc_cfg.fine_gain  <= cfg_data[FINE_GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front end: identifier match.
  tcbs_front #(
    .VOLT_WIDTH (VOLT_WIDTH)
  ) u_front (
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .frame_id      (s_axis_tdata[FRAME_ID_W-1:0]),
    .voltage       (s_axis_tdata[FRAME_ID_W+VOLT_WIDTH-1:FRAME_ID_W]),
    .base_frame_id (base_frame_id),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_data     (push_data)
  );

  // Queue between front and back.
  tcbs_queue #(
    .WIDTH (Q_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Back end: setpoint calculation and result register.
  tcbs_back #(
    .VOLT_WIDTH (VOLT_WIDTH)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .pop_valid        (pop_valid),
    .pop_ready        (pop_ready),
    .pop_data         (pop_data),
    .cfg              (calc_cfg),
    .res_valid        (m_axis_tvalid),
    .res_ready        (m_axis_tready),
    .res_setpoint     (res_setpoint),
    .res_most_deviant (res_most_deviant)
  );

  // Result packing, first field lowest.
  assign m_axis_tdata = {4'b0000, res_most_deviant, res_setpoint[2],
                         res_setpoint[1], res_setpoint[0]};

endmodule

>>> test/tb_three_channel_balance_setpoints_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_three_channel_balance_setpoints_top: self-checking bench for the setpoints
// Feeds voltage frames through the input stream and checks every result beat
// against a cycle-free prediction of the balancing math. It covers a directed
// opening, then random frame groups under several register settings. Both
// stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_three_channel_balance_setpoints_top;
  import tcbs_pkg::*;

  localparam int  VOLT_W       = 32;
  localparam int  IN_W         = ((FRAME_ID_W + VOLT_W + 7) / 8) * 8;
  localparam int  CYCLE_LIMIT  = 1000000;
  localparam int  IDLE_SETTLE  = 80;
  localparam int  PHASE_FRAMES = 195;
  localparam int  PRINT_CAP    = 50;

  typedef struct {
    logic [FRAME_ID_W-1:0] id;
    logic [VOLT_W-1:0]     volt;
  } frame_t;

  typedef struct {
    logic [SETPOINT_W-1:0] sp [NUM_CHAN];
    logic [CHAN_W-1:0]     most_deviant;
  } setpoint_beat_t;

  // Voltage styles used when building stimulus.
  typedef enum int {
    V_ANY,
    V_NEAR,
    V_MODERATE,
    V_COPY,
    V_EXTREME
  } volt_style_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_W-1:0]        s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [71:0]            m_axis_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_BASE_ID;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  three_channel_balance_setpoints_top #(.VOLT_WIDTH(VOLT_W)) uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // Handshake flags sampled at the rising edge, read at the falling edge.
  bit in_fire, out_fire, out_seen;
  int cycle_count, mismatches;
  int frames_queued, frames_taken, frames_ignored, beats_checked, reg_writes;
  int fine_channels, ratio_channels;

  frame_t         frames_pending[$];
  setpoint_beat_t expected_setpoints[$];

  // Predictor copy of the registers and the stored channel voltages.
  logic [FRAME_ID_W-1:0]   cur_base_id;
  logic [FULL_SCALE_W-1:0] cur_full_scale;
  logic [DEAD_BAND_W-1:0]  cur_dead_band;
  logic [FINE_GAIN_W-1:0]  cur_fine_gain;
  longint                  volt_store [NUM_CHAN];

  // Stimulus-side view of the window and the voltages it has queued.
  logic [FRAME_ID_W-1:0]  stim_base = BASE_ID_RST;
  logic [DEAD_BAND_W-1:0] stim_dead_band = DEAD_BAND_RST;
  logic [VOLT_W-1:0]      stim_volts [NUM_CHAN] = '{default: '0};
  int                     stim_center;

  string chan_name [NUM_CHAN] = '{"first", "second", "third"};

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP)
      $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  // Stores the voltage of a frame in the window and works out its setpoints.
  // Returns 0 when the identifier falls outside the window.
  function automatic bit predict_setpoints(input logic [FRAME_ID_W-1:0] fid,
                                           input logic [VOLT_W-1:0] raw,
                                           output setpoint_beat_t beat);
    int                offset;
    int                best;
    longint            mean;
    longint            dev [NUM_CHAN];
    longint unsigned   mag [NUM_CHAN];
    longint unsigned   m;
    longint            sp;
    longint            lim;
    bit                neg;
    offset = int'(fid) - int'(cur_base_id);
    if (offset < 0 || offset > 2)
      return 1'b0;
    volt_store[offset] = longint'($signed(raw));
    mean = (volt_store[0] + volt_store[1] + volt_store[2]) / 3;
    for (int i = 0; i < NUM_CHAN; i++) begin
      dev[i] = mean - volt_store[i];
      mag[i] = (dev[i] < 0) ? -dev[i] : dev[i];
    end
    // Largest magnitude wins; ties keep the lower channel.
    best = 0;
    if (mag[1] > mag[best]) best = 1;
    if (mag[2] > mag[best]) best = 2;
    lim = longint'(OUT_LIMIT);
    for (int i = 0; i < NUM_CHAN; i++) begin
      if (mag[i] <= longint'(cur_dead_band)) begin
        m  = (longint'(cur_fine_gain) * mag[i]) >> FRAC_W;
        sp = (dev[i] > 0) ? -longint'(m) : longint'(m);
        if (mag[i] != 0) fine_channels++;
      end else if (i == best) begin
        sp = (dev[i] > 0) ? -longint'(cur_full_scale) : longint'(cur_full_scale);
      end else begin
        m   = (mag[i] * longint'(cur_full_scale)) / mag[best];
        neg = (dev[i] < 0) != (dev[best] < 0);
        sp  = neg ? -longint'(m) : longint'(m);
        ratio_channels++;
      end
      if (sp > lim) sp = lim;
      if (sp < -lim) sp = -lim;
      beat.sp[i] = sp[SETPOINT_W-1:0];
    end
    beat.most_deviant = best[CHAN_W-1:0];
    return 1'b1;
  endfunction

  // Sample both streams and the register port; predict and check.
  always @(posedge clk) begin : watch
    setpoint_beat_t want;
    logic [SETPOINT_W-1:0] got;
    in_fire  = s_axis_tvalid && s_axis_tready;
    out_fire = m_axis_tvalid && m_axis_tready;
    out_seen = m_axis_tvalid;
    cycle_count++;
    if (rst) begin
      cur_base_id    = BASE_ID_RST;
      cur_full_scale = FULL_SCALE_RST;
      cur_dead_band  = DEAD_BAND_RST;
      cur_fine_gain  = FINE_GAIN_RST;
      volt_store     = '{default: 0};
    end else begin
      if (cfg_valid && cfg_ready) begin
        reg_writes++;
        case (cfg_index_t'(cfg_index))
          CFG_BASE_ID:    cur_base_id    = cfg_data[FRAME_ID_W-1:0];
          CFG_FULL_SCALE: cur_full_scale = cfg_data[FULL_SCALE_W-1:0];
          CFG_DEAD_BAND:  cur_dead_band  = cfg_data[DEAD_BAND_W-1:0];
          CFG_FINE_GAIN:  cur_fine_gain  = cfg_data[FINE_GAIN_W-1:0];
          default: ;
        endcase
      end
      // Result side first, so a beat can never match a frame of this edge.
      if (out_fire) begin
        beats_checked++;
        if (expected_setpoints.size() == 0) begin
          report_mismatch($sformatf("result beat %0d arrived with no frame waiting",
                                    beats_checked));
        end else begin
          want = expected_setpoints.pop_front();
          for (int i = 0; i < NUM_CHAN; i++) begin
            got = m_axis_tdata[i*SETPOINT_W +: SETPOINT_W];
            if (got !== want.sp[i])
              report_mismatch($sformatf("beat %0d setpoint_%s got %0d expected %0d",
                                        beats_checked, chan_name[i], $signed(got),
                                        $signed(want.sp[i])));
          end
          if (m_axis_tdata[3*SETPOINT_W +: CHAN_W] !== want.most_deviant)
            report_mismatch($sformatf("beat %0d most_deviant got %0d expected %0d",
                                      beats_checked,
                                      m_axis_tdata[3*SETPOINT_W +: CHAN_W],
                                      want.most_deviant));
        end
      end
      if (in_fire) begin
        frames_taken++;
        if (predict_setpoints(s_axis_tdata[FRAME_ID_W-1:0],
                              s_axis_tdata[FRAME_ID_W +: VOLT_W], want))
          expected_setpoints.push_back(want);
        else
          frames_ignored++;
      end
    end
  end

  // Frame sender: one beat per queued frame, with a random gap after each.
  int feed_gap;
  bit feed_burst;
  always @(negedge clk) begin : feed
    frame_t f;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      feed_gap = 0;
    end else if (!s_axis_tvalid || in_fire) begin
      if (feed_gap > 0) begin
        s_axis_tvalid <= 1'b0;
        feed_gap--;
      end else if (frames_pending.size() != 0) begin
        f = frames_pending.pop_front();
        s_axis_tdata  <= {{(IN_W-FRAME_ID_W-VOLT_W){1'b0}}, f.volt, f.id};
        s_axis_tvalid <= 1'b1;
        if ($urandom_range(0, 39) == 0) feed_burst = !feed_burst;
        feed_gap = feed_burst ? 0 : $urandom_range(0, 18);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: after each beat, holds ready low for a random stretch
  // that only runs down while a result is on offer.
  int hold_left;
  bit drain_burst;
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_fire) begin
        if ($urandom_range(0, 29) == 0) drain_burst = !drain_burst;
        hold_left = drain_burst ? 0 : $urandom_range(0, 18);
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        if (out_seen) hold_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Runaway guard.
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(negedge clk);
    $display("FAIL three_channel_balance_setpoints_top");
    $finish;
  end

  task automatic queue_frame(input int id, input logic [VOLT_W-1:0] v);
    frame_t f;
    int     offset;
    f.id   = id[FRAME_ID_W-1:0];
    f.volt = v;
    offset = int'(f.id) - int'(stim_base);
    if (offset >= 0 && offset <= 2) stim_volts[offset] = v;
    frames_pending.push_back(f);
    frames_queued++;
  endtask

  task automatic write_register(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_settings(input int base, input int fs, input int db, input int fg);
    write_register(CFG_BASE_ID, CFG_DATA_W'(base));
    write_register(CFG_FULL_SCALE, CFG_DATA_W'(fs));
    write_register(CFG_DEAD_BAND, CFG_DATA_W'(db));
    write_register(CFG_FINE_GAIN, CFG_DATA_W'(fg));
    stim_base      = base[FRAME_ID_W-1:0];
    stim_dead_band = db[DEAD_BAND_W-1:0];
  endtask

  // Wait until every frame is taken and every result checked, then settle.
  task automatic wait_idle();
    while (frames_taken != frames_queued || expected_setpoints.size() != 0)
      @(negedge clk);
    repeat (IDLE_SETTLE) @(negedge clk);
  endtask

  function automatic logic [VOLT_W-1:0] draw_voltage(input volt_style_t style);
    int spread;
    case (style)
      V_NEAR: begin
        spread = int'(stim_dead_band) + 8;
        return stim_center + int'($urandom_range(0, 2 * spread)) - spread;
      end
      V_MODERATE: return int'($urandom_range(0, 2 * 1048576)) - 1048576;
      V_COPY:     return stim_volts[$urandom_range(0, 2)];
      V_EXTREME: begin
        case ($urandom_range(0, 3))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return 32'hFFFF_FFFF;
          default: return '0;
        endcase
      end
      default:    return $urandom;
    endcase
  endfunction

  // Groups of three frames, one per channel in rotating order, mostly in one voltage
  // style, with unrelated identifiers mixed in. Stops once count frames of
  // any kind are queued; window slots past the identifier range wrap around.
  task automatic run_random_frames(input int count);
    int          queued;
    int          start;
    int          idv;
    volt_style_t style;
    queued = 0;
    stim_center = int'($urandom) >>> $urandom_range(4, 24);
    while (queued < count) begin
      case ($urandom_range(0, 9))
        0, 1, 2: style = V_NEAR;
        3, 4:    style = V_MODERATE;
        5:       style = V_COPY;
        6:       style = V_EXTREME;
        default: style = V_ANY;
      endcase
      start = $urandom_range(0, 2);
      for (int j = 0; j < 3; j++) begin
        if ($urandom_range(0, 99) < 15) begin
          queue_frame($urandom_range(0, 2047), $urandom);
          queued++;
        end
        idv = int'(stim_base) + (start + j) % 3;
        queue_frame(idv, draw_voltage(($urandom_range(0, 4) == 0) ? V_ANY : style));
        queued++;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed opening under the reset register values.
    queue_frame(16, 32'd0);
    queue_frame(16, 32'h7FFF_FFFF);
    queue_frame(17, 32'h8000_0000);
    queue_frame(18, 32'h7FFF_FFFF);
    queue_frame(18, 32'h8000_0000);
    queue_frame(15, $urandom);
    queue_frame(19, $urandom);
    queue_frame(0, 32'hFFFF_FFFF);
    queue_frame(2047, 32'd0);
    // Equal voltages, then a small step inside the dead band, then a big one.
    queue_frame(16, 32'd65536);
    queue_frame(17, 32'd65536);
    queue_frame(18, 32'd65536);
    queue_frame(17, 32'd65836);
    queue_frame(18, 32'd196608);
    // Ties for the largest deviation, first between channels 0 and 1,
    // then between channels 1 and 2.
    queue_frame(16, 32'd0);
    queue_frame(17, 32'd200000);
    queue_frame(18, 32'd100000);
    queue_frame(16, 32'd100000);
    queue_frame(17, 32'd0);
    queue_frame(18, 32'd200000);
    // Negative sum: the mean truncates toward zero.
    queue_frame(16, -32'sd1);
    queue_frame(17, -32'sd1);
    queue_frame(18, 32'd0);
    run_random_frames(PHASE_FRAMES);
    wait_idle();

    // Extreme settings: low window edge, zero fine gain and dead band.
    write_settings(0, 1048576, 0, 0);
    run_random_frames(PHASE_FRAMES);
    wait_idle();
    // Window at the top: base+1 and base+2 lie past the identifier range.
    write_settings(2047, 0, 65536, 1048576);
    run_random_frames(PHASE_FRAMES);
    wait_idle();
    // Register values above the output range saturate.
    write_settings(2045, 2097151, 131071, 2097151);
    run_random_frames(PHASE_FRAMES);
    wait_idle();
    write_settings(2046, 1, 1, 1);
    run_random_frames(PHASE_FRAMES);
    wait_idle();
    for (int p = 0; p < 4; p++) begin
      write_settings($urandom_range(0, 2047), $urandom_range(0, 1048576),
                     $urandom_range(0, 65536), $urandom_range(0, 1048576));
      run_random_frames(PHASE_FRAMES);
      wait_idle();
    end
    write_settings(BASE_ID_RST, FULL_SCALE_RST, DEAD_BAND_RST, FINE_GAIN_RST);
    run_random_frames(PHASE_FRAMES);
    wait_idle();

    if (expected_setpoints.size() != 0)
      report_mismatch($sformatf("%0d expected result beats never arrived",
                                expected_setpoints.size()));
    $display("Sent %0d frames (%0d outside the window), checked %0d setpoint beats.",
             frames_taken, frames_ignored, beats_checked);
    $display("Register writes: %0d; fine-gain channels: %0d; ratio channels: %0d.",
             reg_writes, fine_channels, ratio_channels);
    if (mismatches == 0) begin
      $display("PASS three_channel_balance_setpoints_top");
    end else begin
      $display("FAIL three_channel_balance_setpoints_top");
    end
    $finish;
  end

endmodule
